[hdl/skt_pkg.sv]
package skt_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 6;
   localparam int STAT_W = 3;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SETV   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SETT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MINMAX = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DUP     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BADIDX  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_ZEROINT = 3'd4;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT,
      ST_PROBE,
      ST_PLACE,
      ST_FIN
   } state_type;

   // outcome of the shared compare unit
   typedef struct packed {
      logic lt;   // probe below low reference (signed)
      logic eq;   // probe equals low reference
      logic gt;   // probe above high reference (signed)
   } cmp_res_type;

endpackage

[hdl/skt_ram.sv]
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/skt_cmp.sv]
module skt_cmp (
   input  skt_pkg::data_type    probe,
   input  skt_pkg::data_type    lo_ref,
   input  skt_pkg::data_type    hi_ref,
   output skt_pkg::cmp_res_type res
);

   // one signed compare against each reference, plus equality
   always_comb begin
      res.lt = (probe < lo_ref);
      res.eq = (probe == lo_ref);
      res.gt = (probe > hi_ref);
   end

endmodule

[hdl/sorted_knot_table.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  cmd, slot_index, key_time, knot_value
// rsp      out        rsp_valid / rsp_ready  status, position, read_time, read_value,
//                                            min_value, max_value, count
//
// An insert scans every knot held, then shifts the knots from the insert position up and
//   writes the new knot; a delete shifts the knots above slot_index down; min/max scans all knots.
// Reset clears the knot count, handshake state and the pend/more flags only; no RAM clearing pass.
// req_ready is high only while idle; a finished result waits in the output register
//   for rsp_ready while the next transaction is taken in.
module sorted_knot_table #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [skt_pkg::CMD_W-1:0]         req_cmd,
   input  logic [skt_pkg::IDX_W-1:0]         req_slot_index,
   input  logic signed [skt_pkg::DATA_W-1:0] req_key_time,
   input  logic signed [skt_pkg::DATA_W-1:0] req_knot_value,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [skt_pkg::STAT_W-1:0]        rsp_status,
   output logic [skt_pkg::POS_W-1:0]         rsp_position,
   output logic signed [skt_pkg::DATA_W-1:0] rsp_read_time,
   output logic signed [skt_pkg::DATA_W-1:0] rsp_read_value,
   output logic signed [skt_pkg::DATA_W-1:0] rsp_min_value,
   output logic signed [skt_pkg::DATA_W-1:0] rsp_max_value,
   output logic [skt_pkg::CNT_W-1:0]         rsp_count
);

   localparam int AW = $clog2(CAPACITY);      // RAM address width
   localparam int CW = $clog2(CAPACITY + 1);  // holds 0..CAPACITY

   // sequencer
   skt_pkg::state_type state_ff, state_in;

   // captured transaction
   logic [skt_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [skt_pkg::IDX_W-1:0] idx_ff, idx_in;
   skt_pkg::data_type         kt_ff, kt_in;
   skt_pkg::data_type         kv_ff, kv_in;

   // table occupancy
   logic [CW-1:0] count_ff, count_in;

   // walk control
   logic [CW-1:0] ptr_ff, ptr_in;      // next RAM address to read
   logic [CW-1:0] stop_ff, stop_in;    // last address of a shift
   logic [AW-1:0] wa_ff, wa_in;        // where the word in flight lands
   logic          pend_ff, pend_in;    // read data due this cycle
   logic          more_ff, more_in;    // shift reads still to issue
   logic          first_ff, first_in;  // first value of a min/max walk
   logic          dup_ff, dup_in;
   logic          found_ff, found_in;

   // result under construction
   logic [skt_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic [CW-1:0]              pos_ff, pos_in;
   skt_pkg::data_type          rt_ff, rt_in;
   skt_pkg::data_type          rv_ff, rv_in;
   skt_pkg::data_type          mn_ff, mn_in;
   skt_pkg::data_type          mx_ff, mx_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [skt_pkg::STAT_W-1:0] rsp_status_ff;
   logic [skt_pkg::POS_W-1:0]  rsp_position_ff;
   skt_pkg::data_type          rsp_read_time_ff;
   skt_pkg::data_type          rsp_read_value_ff;
   skt_pkg::data_type          rsp_min_value_ff;
   skt_pkg::data_type          rsp_max_value_ff;
   logic [skt_pkg::CNT_W-1:0]  rsp_count_ff;
   logic                       load_rsp;

   // RAM ports
   logic [AW-1:0]     rd_addr;
   logic              t_we, v_we;
   logic [AW-1:0]     t_wa, v_wa;
   skt_pkg::data_type t_wd, v_wd;
   skt_pkg::data_type t_rdata, v_rdata;

   // shared comparator
   skt_pkg::data_type   cmp_probe, cmp_lo;
   skt_pkg::cmp_res_type cmp_res;

   logic          idx_ok;
   logic [CW-1:0] idx_c;
   logic [AW-1:0] idx_a;
   logic          shift_up;

   skt_ram #(.WIDTH(skt_pkg::DATA_W), .DEPTH(CAPACITY)) u_time_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_wa),
      .wr_data (t_wd),
      .rd_addr (rd_addr),
      .rd_data (t_rdata)
   );

   skt_ram #(.WIDTH(skt_pkg::DATA_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_wa),
      .wr_data (v_wd),
      .rd_addr (rd_addr),
      .rd_data (v_rdata)
   );

   // min/max compares values against the running extremes, everything
   // else compares times against the key
   assign cmp_probe = (cmd_ff == skt_pkg::CMD_MINMAX) ? v_rdata : t_rdata;
   assign cmp_lo    = (cmd_ff == skt_pkg::CMD_MINMAX) ? mn_ff : kt_ff;

   skt_cmp u_cmp (
      .probe  (cmp_probe),
      .lo_ref (cmp_lo),
      .hi_ref (mx_ff),
      .res    (cmp_res)
   );

   // slot index checks against the live count, widths aligned
   assign idx_ok   = ({6'd0, count_ff} > {{CW{1'b0}}, idx_ff});
   assign idx_c    = CW'(idx_ff);
   assign idx_a    = AW'(idx_ff);
   assign shift_up = (cmd_ff == skt_pkg::CMD_INSERT);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      kt_in        = kt_ff;
      kv_in        = kv_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      wa_in        = wa_ff;
      pend_in      = 1'b0;
      more_in      = more_ff;
      first_in     = first_ff;
      dup_in       = dup_ff;
      found_in     = found_ff;
      stat_in      = stat_ff;
      pos_in       = pos_ff;
      rt_in        = rt_ff;
      rv_in        = rv_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      load_rsp     = 1'b0;

      rd_addr      = ptr_ff[AW-1:0];
      t_we         = 1'b0;
      t_wa         = wa_ff;
      t_wd         = t_rdata;
      v_we         = 1'b0;
      v_wa         = wa_ff;
      v_wd         = v_rdata;

      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               idx_in   = req_slot_index;
               kt_in    = req_key_time;
               kv_in    = req_knot_value;
               stat_in  = skt_pkg::STAT_OK;
               pos_in   = '0;
               rt_in    = '0;
               rv_in    = '0;
               mn_in    = '0;
               mx_in    = '0;
               ptr_in   = '0;
               dup_in   = 1'b0;
               found_in = 1'b0;
               first_in = 1'b1;
               state_in = skt_pkg::ST_DISPATCH;
            end
         end

         skt_pkg::ST_DISPATCH: begin
            unique case (cmd_ff)
               skt_pkg::CMD_INSERT: begin
                  // empty table falls straight through the scan
                  state_in = skt_pkg::ST_SCAN;
               end
               skt_pkg::CMD_DELETE: begin
                  if (!idx_ok) begin
                     stat_in  = skt_pkg::STAT_BADIDX;
                     state_in = skt_pkg::ST_FIN;
                  end else begin
                     ptr_in   = idx_c + CW'(1);
                     stop_in  = count_ff - CW'(1);
                     more_in  = ((idx_c + CW'(1)) < count_ff);
                     state_in = skt_pkg::ST_SHIFT;
                  end
               end
               skt_pkg::CMD_SETV: begin
                  if (!idx_ok) begin
                     stat_in = skt_pkg::STAT_BADIDX;
                  end else begin
                     v_we = 1'b1;
                     v_wa = idx_a;
                     v_wd = kv_ff;
                  end
                  state_in = skt_pkg::ST_FIN;
               end
               skt_pkg::CMD_SETT: begin
                  if (!idx_ok) begin
                     stat_in  = skt_pkg::STAT_BADIDX;
                     state_in = skt_pkg::ST_FIN;
                  end else if (idx_c == '0 && count_ff < CW'(2)) begin
                     // lone knot: no neighbour to clash with
                     t_we     = 1'b1;
                     t_wa     = idx_a;
                     t_wd     = kt_ff;
                     state_in = skt_pkg::ST_FIN;
                  end else begin
                     // slot 0 checks the next knot, others the previous
                     rd_addr  = (idx_c == '0) ? AW'(1) : AW'(idx_c - CW'(1));
                     state_in = skt_pkg::ST_PROBE;
                  end
               end
               skt_pkg::CMD_READ: begin
                  if (!idx_ok) begin
                     stat_in  = skt_pkg::STAT_BADIDX;
                     state_in = skt_pkg::ST_FIN;
                  end else begin
                     rd_addr  = idx_a;
                     state_in = skt_pkg::ST_PROBE;
                  end
               end
               skt_pkg::CMD_MINMAX: begin
                  state_in = (count_ff == '0) ? skt_pkg::ST_FIN : skt_pkg::ST_SCAN;
               end
               default: begin
                  state_in = skt_pkg::ST_FIN;
               end
            endcase
         end

         skt_pkg::ST_SCAN: begin
            // one read issued per cycle, its data compared in the next cycle
            if (ptr_ff != count_ff) begin
               pend_in = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
            end
            if (pend_ff) begin
               if (cmd_ff == skt_pkg::CMD_MINMAX) begin
                  if (first_ff) begin
                     mn_in    = v_rdata;
                     mx_in    = v_rdata;
                     first_in = 1'b0;
                  end else begin
                     if (cmp_res.lt) mn_in = v_rdata;
                     if (cmp_res.gt) mx_in = v_rdata;
                  end
               end else begin
                  if (cmp_res.eq) dup_in = 1'b1;
                  if (!found_ff) begin
                     if (cmp_res.lt) begin
                        pos_in = pos_ff + CW'(1);
                     end else begin
                        found_in = 1'b1;
                     end
                  end
               end
            end
            if (!pend_ff && ptr_ff == count_ff) begin
               priority if (cmd_ff == skt_pkg::CMD_MINMAX) begin
                  state_in = skt_pkg::ST_FIN;
               end else if (dup_ff) begin
                  // rejected inserts report position 0
                  stat_in  = skt_pkg::STAT_DUP;
                  pos_in   = '0;
                  state_in = skt_pkg::ST_FIN;
               end else if (count_ff == CW'(CAPACITY)) begin
                  stat_in  = skt_pkg::STAT_FULL;
                  pos_in   = '0;
                  state_in = skt_pkg::ST_FIN;
               end else if (pos_ff == count_ff) begin
                  state_in = skt_pkg::ST_PLACE;
               end else begin
                  // move knots pos..count-1 up by one, top first
                  ptr_in   = count_ff - CW'(1);
                  stop_in  = pos_ff;
                  more_in  = 1'b1;
                  state_in = skt_pkg::ST_SHIFT;
               end
            end
         end

         skt_pkg::ST_SHIFT: begin
            if (more_ff) begin
               pend_in = 1'b1;
               wa_in   = shift_up ? AW'(ptr_ff + CW'(1)) : AW'(ptr_ff - CW'(1));
               if (ptr_ff == stop_ff) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = shift_up ? (ptr_ff - CW'(1)) : (ptr_ff + CW'(1));
               end
            end
            if (pend_ff) begin
               t_we = 1'b1;
               v_we = 1'b1;
            end
            if (!more_ff && !pend_ff) begin
               if (shift_up) begin
                  state_in = skt_pkg::ST_PLACE;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = skt_pkg::ST_FIN;
               end
            end
         end

         skt_pkg::ST_PROBE: begin
            if (cmd_ff == skt_pkg::CMD_READ) begin
               rt_in = t_rdata;
               rv_in = v_rdata;
            end else if (cmp_res.eq) begin
               stat_in = skt_pkg::STAT_ZEROINT;
            end else begin
               t_we = 1'b1;
               t_wa = idx_a;
               t_wd = kt_ff;
            end
            state_in = skt_pkg::ST_FIN;
         end

         skt_pkg::ST_PLACE: begin
            t_we     = 1'b1;
            t_wa     = pos_ff[AW-1:0];
            t_wd     = kt_ff;
            v_we     = 1'b1;
            v_wa     = pos_ff[AW-1:0];
            v_wd     = kv_ff;
            count_in = count_ff + CW'(1);
            state_in = skt_pkg::ST_FIN;
         end

         skt_pkg::ST_FIN: begin
            // wait here while an older result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = skt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      kt_ff    <= kt_in;
      kv_ff    <= kv_in;
      ptr_ff   <= ptr_in;
      stop_ff  <= stop_in;
      wa_ff    <= wa_in;
      first_ff <= first_in;
      dup_ff   <= dup_in;
      found_ff <= found_in;
      stat_ff  <= stat_in;
      pos_ff   <= pos_in;
      rt_ff    <= rt_in;
      rv_ff    <= rv_in;
      mn_ff    <= mn_in;
      mx_ff    <= mx_in;
      if (load_rsp) begin
         rsp_status_ff     <= stat_ff;
         rsp_position_ff   <= skt_pkg::POS_W'(pos_ff);
         rsp_read_time_ff  <= rt_ff;
         rsp_read_value_ff <= rv_ff;
         rsp_min_value_ff  <= mn_ff;
         rsp_max_value_ff  <= mx_ff;
         rsp_count_ff      <= skt_pkg::CNT_W'(count_ff);
      end
   end

   assign req_ready      = (state_ff == skt_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_read_time  = rsp_read_time_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_min_value  = rsp_min_value_ff;
   assign rsp_max_value  = rsp_max_value_ff;
   assign rsp_count      = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("knot count beyond capacity");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == skt_pkg::STAT_FULL) |->
      (rsp_count == skt_pkg::CNT_W'(CAPACITY)))
      else $error("full status without a full table");

   a_no_write_when_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ST_IDLE || state_ff == skt_pkg::ST_FIN) |-> (!t_we && !v_we))
      else $error("RAM write outside a command");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && state_ff == skt_pkg::ST_FIN) |=>
      (state_ff == skt_pkg::ST_FIN))
      else $error("held result overwritten");
`endif

endmodule
